[design/binary_trie_max_xor_defines.svh]
// ----------------------------------------------------------------------------
// binary_trie_max_xor_defines
// assertion macros shared by the trie block
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BTMX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BTMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// types, constants and codes of the binary trie maximum xor block
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int KEY_BITS   = 32;

  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int NF_W       = NODE_BITS + 1;
  localparam int ROW_W      = 2 * NODE_BITS;
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } btmx_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } btmx_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } btmx_state_e;

  typedef struct packed {
    btmx_func_e  func;
    logic [31:0] key_value;
  } btmx_in_t;

  typedef struct packed {
    logic [31:0]  best_xor;
    btmx_status_e status;
  } btmx_out_t;

  // node store access, one read and one write port
  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    logic [ROW_W-1:0]     wdata;
    logic [NODE_BITS-1:0] raddr;
  } btmx_mem_req_t;

  typedef struct packed {
    logic      valid;
    btmx_out_t item;
  } btmx_res_t;

endpackage

[design/btmx_node_store.sv]
// ----------------------------------------------------------------------------
// btmx_node_store
// node rows of the trie, one row holds both child pointers of a node
// ----------------------------------------------------------------------------
module btmx_node_store (
  input  logic                            clk_i,
  input  btmx_pkg::btmx_mem_req_t         req_i,
  output logic [btmx_pkg::ROW_W-1:0]      rd_data_o
);
  import btmx_pkg::*;

  logic [ROW_W-1:0] mem [NODE_COUNT];
  logic [ROW_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  assign rd_data_o = rd_q;

endmodule

[design/btmx_walk_ctrl.sv]
// ----------------------------------------------------------------------------
// btmx_walk_ctrl
// walks the trie one level per cycle for inserts and queries
// ----------------------------------------------------------------------------
`include "binary_trie_max_xor_defines.svh"

module btmx_walk_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  btmx_pkg::btmx_in_t            in_data_i,
  output btmx_pkg::btmx_mem_req_t       mem_req_o,
  input  logic [btmx_pkg::ROW_W-1:0]    rd_data_i,
  output btmx_pkg::btmx_res_t           res_o,
  input  logic                          res_ready_i
);
  import btmx_pkg::*;

  btmx_state_e state_q, state_d;
  logic [NF_W-1:0]      nf_q, nf_d;
  logic                 nonempty_q, nonempty_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [NODE_BITS-1:0] node_q, node_d;
  logic                 new_q, new_d;
  btmx_func_e           func_q, func_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [KEY_BITS-1:0]  res_q, res_d;
  btmx_status_e         st_q, st_d;

  logic [ROW_W-1:0]     row_eff;
  logic [NODE_BITS-1:0] c0, c1, sel, oth, nxt;
  logic                 kbit;
  logic [NF_W-1:0]      free_nodes;
  logic                 accept;

  assign row_eff    = new_q ? '0 : rd_data_i;
  assign c0         = row_eff[NODE_BITS-1:0];
  assign c1         = row_eff[ROW_W-1:NODE_BITS];
  assign kbit       = key_q[level_q];
  assign sel        = kbit ? c1 : c0;
  assign oth        = kbit ? c0 : c1;
  assign free_nodes = NF_W'(NODE_COUNT) - nf_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    nf_d       = nf_q;
    nonempty_d = nonempty_q;
    level_d    = level_q;
    node_d     = node_q;
    new_d      = new_q;
    func_d     = func_q;
    key_d      = key_q;
    res_d      = res_q;
    st_d       = st_q;
    nxt        = sel;
    mem_req_o  = '0;
    res_o.valid         = 1'b0;
    res_o.item.best_xor = 32'(res_q);
    res_o.item.status   = st_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d  = in_data_i.func;
          key_d   = in_data_i.key_value[KEY_BITS-1:0];
          res_d   = '0;
          node_d  = '0;
          level_d = LVL_W'(KEY_BITS - 1);
          new_d   = !nonempty_q;
          st_d    = ST_OK;
          if (in_data_i.func == FUNC_QUERY && !nonempty_q) begin
            st_d    = ST_EMPTY;
            state_d = S_DONE;
          end else if (in_data_i.func == FUNC_INSERT && free_nodes < NF_W'(KEY_BITS)) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            // root row read, data arrives for the first level
            if (in_data_i.func == FUNC_INSERT) begin
              nonempty_d = 1'b1;
            end
            mem_req_o.raddr = '0;
            state_d         = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (func_q == FUNC_INSERT) begin
          if (sel == '0) begin
            // missing child: allocate and patch this row, below it all is new
            nxt             = nf_q[NODE_BITS-1:0];
            nf_d            = nf_q + NF_W'(1);
            new_d           = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = node_q;
            mem_req_o.wdata = kbit ? {nf_q[NODE_BITS-1:0], c0} : {c1, nf_q[NODE_BITS-1:0]};
          end
        end else begin
          if (oth != '0) begin
            nxt            = oth;
            res_d[level_q] = 1'b1;
          end
        end
        mem_req_o.raddr = nxt;
        node_d          = nxt;
        if (level_q == '0) begin
          state_d = S_DONE;
        end else begin
          level_d = level_q - LVL_W'(1);
        end
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nf_q       <= NF_W'(1);
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nf_q       <= nf_d;
      nonempty_q <= nonempty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    node_q  <= node_d;
    new_q   <= new_d;
    func_q  <= func_d;
    key_q   <= key_d;
    res_q   <= res_d;
    st_q    <= st_d;
  end

  `BTMX_ASSERT_NOW(a_no_same_row, clk_i, rst_ni, mem_req_o.we, mem_req_o.waddr != mem_req_o.raddr, "row written and read together")
  `BTMX_ASSERT_NOW(a_nf_bound, clk_i, rst_ni, 1'b1, nf_q <= NF_W'(NODE_COUNT), "free pointer beyond store")
  `BTMX_ASSERT_NEXT(a_nonempty_sticky, clk_i, rst_ni, nonempty_q, nonempty_q, "trie became empty")

endmodule

[design/binary_trie_max_xor.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// binary trie of keys with insert and maximum xor query
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid_i / in_stall_o / in_data_i : func and key_value
//   output channel out_valid_o / out_stall_i / out_data_o : best_xor, status
//   one result per input transfer, in order
// sequence
//   a walked insert or query reads one node row per key level, the root
//   read issued at its input transfer, then hands its result to the
//   output register that drives out_valid_o; a refused insert or an
//   empty query skips the walk and goes straight to the hand-over
//   the next input transfer is taken the cycle after the result is
//   registered, so no new item enters while one walks or waits to hand over
// reset
//   the trie is empty, the root is allocated; node rows carry no reset and
//   need no clearing pass: each row is fully written when its node is first
//   given a child, and the root row reads as empty until the first insert
// stall
//   a result waiting under out_stall_i holds the output register; one more
//   item may walk meanwhile and then waits until the register is free
module binary_trie_max_xor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  btmx_pkg::btmx_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output btmx_pkg::btmx_out_t   out_data_o
);
  import btmx_pkg::*;

  btmx_mem_req_t    mem_req;
  logic [ROW_W-1:0] rd_data;
  btmx_res_t        res;
  logic             res_ready;

  logic      out_valid_q, out_valid_d;
  btmx_out_t out_q;

  // node store, one read and one write each cycle
  btmx_node_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // walk sequencer
  btmx_walk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register is free when empty or its transfer completes now
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
